### hw/rtl/sorted_term_frequency_table_macros.svh
// Assertion macros shared by the table RTL.
`ifndef SORTED_TERM_FREQUENCY_TABLE_MACROS_SVH
`define SORTED_TERM_FREQUENCY_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define STFQ_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define STFQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hw/rtl/stfq_pkg.sv
`default_nettype none
package stfq_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_CODE_BITS   = 16;
  localparam int DEF_COUNT_BITS  = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_END = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic add_hit;
    logic add_ins;
    logic shift_left;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/stfq_cell.sv
`default_nettype none
module stfq_cell #(
  parameter int TABLE_DEPTH = 64,
  parameter int CODE_BITS   = 16,
  parameter int COUNT_BITS  = 16,
  parameter int IDX         = 0
) (
  input  wire                                   clk,
  input  stfq_pkg::cell_ctrl_t                  ctrl,
  input  wire [CODE_BITS-1:0]                   new_code,
  input  wire [$clog2(TABLE_DEPTH+1)-1:0]       used,
  input  wire [CODE_BITS-1:0]                   prev_code,
  input  wire [COUNT_BITS-1:0]                  prev_count,
  input  wire                                   prev_lt,
  input  wire [CODE_BITS-1:0]                   next_code,
  input  wire [COUNT_BITS-1:0]                  next_count,
  output logic [CODE_BITS-1:0]                  code,
  output logic [COUNT_BITS-1:0]                 count,
  output logic                                  lt,
  output logic                                  match,
  output logic [COUNT_BITS-1:0]                 hit_count
);
  import stfq_pkg::*;

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic                  in_use;
  logic [COUNT_BITS-1:0] inc_count;

  assign in_use    = UW'(IDX) < used;
  assign lt        = in_use && (code < new_code);
  assign match     = in_use && (code == new_code);
  assign inc_count = (count == {COUNT_BITS{1'b1}}) ? count : count + COUNT_BITS'(1);
  assign hit_count = match ? inc_count : '0;

  always_ff @(posedge clk) begin
    if (ctrl.shift_left) begin
      code  <= next_code;
      count <= next_count;
    end else if (ctrl.add_hit && match) begin
      count <= inc_count;
    end else if (ctrl.add_ins && !lt) begin
      if (prev_lt) begin
        code  <= new_code;
        count <= COUNT_BITS'(1);
      end else begin
        code  <= prev_code;
        count <= prev_count;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_term_frequency_table.sv
`default_nettype none
// Sorted term-frequency table.
// Request channel: present opcode and term_code with start high; the request
// is taken at a clock edge where busy is low. Opcode add counts a term code,
// opcode end-of-document dumps the table in ascending code order and clears it.
// Result channel: every result shows for one cycle with result_strobe high;
// the receiver must take it then, as it cannot stall the block.
// Add: one acknowledge, in the cycle after the request; busy stays low, so adds
// are taken every cycle. The table is a row of cells; each compares the
// broadcast code, and the ones above the insert point shift one place right.
// End of document with entries: busy goes high, and entries come out of cell 0
// one per cycle as the row shifts left; busy falls as the last entry is
// registered, and the next request is taken at the edge ending the last entry.
// An empty table gives one empty marker in the next cycle after the request.
// Reset clears the entry count, the dump state and the result strobe; cell
// contents are held until overwritten.
module sorted_term_frequency_table #(
  parameter int TABLE_DEPTH = stfq_pkg::DEF_TABLE_DEPTH,
  parameter int CODE_BITS   = stfq_pkg::DEF_CODE_BITS,
  parameter int COUNT_BITS  = stfq_pkg::DEF_COUNT_BITS
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode,
  input  wire [CODE_BITS-1:0]                term_code,
  output logic                               result_strobe,
  output logic [1:0]                         result_kind,
  output logic [CODE_BITS-1:0]               entry_code,
  output logic [COUNT_BITS-1:0]              entry_count,
  output logic                               was_inserted,
  output logic                               table_full_drop,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   entries_used,
  output logic                               last_of_run
);
  import stfq_pkg::*;
  `include "sorted_term_frequency_table_macros.svh"

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic                  dumping;
  logic [UW-1:0]         used;
  logic                  accept;
  logic                  add_req;
  logic                  end_req;
  logic                  any_match;
  logic                  full;
  logic [COUNT_BITS-1:0] hit_sum;
  cell_ctrl_t            ctrl;

  logic [CODE_BITS-1:0]  c_code  [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] c_count [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] c_hit   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] c_lt;
  logic [TABLE_DEPTH-1:0] c_match;

  assign busy      = dumping;
  assign accept    = start && !dumping;
  assign add_req   = accept && (opcode == OP_ADD);
  assign end_req   = accept && (opcode == OP_END);
  assign any_match = |c_match;
  assign full      = used == UW'(TABLE_DEPTH);

  assign ctrl.add_hit    = add_req && any_match;
  assign ctrl.add_ins    = add_req && !any_match && !full;
  assign ctrl.shift_left = dumping;

  always_comb begin
    hit_sum = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_sum = hit_sum | c_hit[i];
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [CODE_BITS-1:0]  p_code;
    logic [COUNT_BITS-1:0] p_count;
    logic                  p_lt;
    logic [CODE_BITS-1:0]  n_code;
    logic [COUNT_BITS-1:0] n_count;

    if (g == 0) begin : g_first
      assign p_code  = '0;
      assign p_count = '0;
      assign p_lt    = 1'b1;
    end else begin : g_mid
      assign p_code  = c_code[g-1];
      assign p_count = c_count[g-1];
      assign p_lt    = c_lt[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign n_code  = '0;
      assign n_count = '0;
    end else begin : g_inner
      assign n_code  = c_code[g+1];
      assign n_count = c_count[g+1];
    end

    stfq_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CODE_BITS   (CODE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .IDX         (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_code   (term_code),
      .used       (used),
      .prev_code  (p_code),
      .prev_count (p_count),
      .prev_lt    (p_lt),
      .next_code  (n_code),
      .next_count (n_count),
      .code       (c_code[g]),
      .count      (c_count[g]),
      .lt         (c_lt[g]),
      .match      (c_match[g]),
      .hit_count  (c_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dumping       <= 1'b0;
      used          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (dumping) begin
        result_strobe <= 1'b1;
        used          <= used - UW'(1);
        if (used == UW'(1)) begin
          dumping <= 1'b0;
        end
      end else if (end_req) begin
        if (used == '0) begin
          result_strobe <= 1'b1;
        end else begin
          dumping <= 1'b1;
        end
      end else if (add_req) begin
        result_strobe <= 1'b1;
        if (ctrl.add_ins) begin
          used <= used + UW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dumping) begin
      result_kind     <= KIND_ENTRY;
      entry_code      <= c_code[0];
      entry_count     <= c_count[0];
      was_inserted    <= 1'b0;
      table_full_drop <= 1'b0;
      entries_used    <= '0;
      last_of_run     <= used == UW'(1);
    end else if (end_req) begin
      result_kind     <= KIND_EMPTY;
      entry_code      <= '0;
      entry_count     <= '0;
      was_inserted    <= 1'b0;
      table_full_drop <= 1'b0;
      entries_used    <= '0;
      last_of_run     <= 1'b1;
    end else begin
      result_kind     <= KIND_ACK;
      entry_code      <= term_code;
      was_inserted    <= ctrl.add_ins;
      table_full_drop <= !any_match && full;
      entries_used    <= ctrl.add_ins ? used + UW'(1) : used;
      last_of_run     <= 1'b1;
      priority if (any_match) begin
        entry_count <= hit_sum;
      end else if (full) begin
        entry_count <= '0;
      end else begin
        entry_count <= COUNT_BITS'(1);
      end
    end
  end

  `STFQ_ASSERT(a_used_bound, used <= UW'(TABLE_DEPTH), "entry count beyond table depth")
  `STFQ_ASSERT_IMP(a_dump_nonempty, dumping, used != '0, "dump running on an empty table")
  `STFQ_ASSERT_NEXT(a_add_ack, add_req, result_strobe && result_kind == KIND_ACK, "no acknowledge")
  `STFQ_ASSERT_IMP(a_single_hit, add_req, $onehot0(c_match), "term code held in two cells")
  `STFQ_ASSERT_IMP(a_flags, result_strobe, !(was_inserted && table_full_drop), "insert with drop")

endmodule
`default_nettype wire

### sim/term_table_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module term_table_checker
  import stfq_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CODE_BITS   = DEF_CODE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int USED_BITS   = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire                  busy,
  input  wire                  opcode,
  input  wire [CODE_BITS-1:0]  term_code,
  input  wire                  result_strobe,
  input  wire [1:0]            result_kind,
  input  wire [CODE_BITS-1:0]  entry_code,
  input  wire [COUNT_BITS-1:0] entry_count,
  input  wire                  was_inserted,
  input  wire                  table_full_drop,
  input  wire [USED_BITS-1:0]  entries_used,
  input  wire                  last_of_run,
  output int                   fail_count,
  output int                   pending,
  output int                   results_checked,
  output int                   drops_seen,
  output int                   saturated_seen
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CODE_BITS-1:0]  code;
    logic [COUNT_BITS-1:0] count;
    logic                  ins;
    logic                  drop;
    logic [USED_BITS-1:0]  used;
    logic                  last;
  } term_result_t;

  logic [CODE_BITS-1:0]  held_code  [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] held_count [TABLE_DEPTH];
  int                    held_used;
  term_result_t          expected_results[$];

  task automatic tally_request(input logic op, input logic [CODE_BITS-1:0] code);
    int pos;
    term_result_t r;
    r = '0;
    if (op == OP_END) begin
      if (held_used == 0) begin
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        expected_results.push_back(r);
      end else begin
        for (int k = 0; k < held_used; k++) begin
          r.kind  = KIND_ENTRY;
          r.code  = held_code[k];
          r.count = held_count[k];
          r.last  = (k == held_used - 1);
          expected_results.push_back(r);
        end
        held_used = 0;
      end
      return;
    end
    pos = 0;
    while (pos < held_used && held_code[pos] < code) pos++;
    r.kind = KIND_ACK;
    r.code = code;
    r.last = 1'b1;
    if (pos < held_used && held_code[pos] == code) begin
      if (held_count[pos] != COUNT_MAX) held_count[pos]++;
      else saturated_seen++;
      r.count = held_count[pos];
      r.used  = USED_BITS'(held_used);
    end else if (held_used >= TABLE_DEPTH) begin
      r.drop = 1'b1;
      r.used = USED_BITS'(held_used);
      drops_seen++;
    end else begin
      for (int i = held_used; i > pos; i--) begin
        held_code[i]  = held_code[i-1];
        held_count[i] = held_count[i-1];
      end
      held_code[pos]  = code;
      held_count[pos] = COUNT_BITS'(1);
      held_used++;
      r.count = COUNT_BITS'(1);
      r.ins   = 1'b1;
      r.used  = USED_BITS'(held_used);
    end
    expected_results.push_back(r);
  endtask

  function automatic bit field_ok(string name, longint unsigned want, longint unsigned got);
    if (want != got)
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    return want == got;
  endfunction

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    drops_seen      = 0;
    saturated_seen  = 0;
    held_used       = 0;
  end

  always @(posedge clk) begin
    term_result_t want;
    bit ok;
    if (rst) begin
      held_used = 0;
      expected_results.delete();
    end else begin
      if (result_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected none actual kind %0d code %0d",
                   $time, result_kind, entry_code);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          ok = 1'b1;
          ok &= field_ok("result_kind", want.kind, result_kind);
          ok &= field_ok("entry_code", want.code, entry_code);
          ok &= field_ok("entry_count", want.count, entry_count);
          ok &= field_ok("was_inserted", want.ins, was_inserted);
          ok &= field_ok("table_full_drop", want.drop, table_full_drop);
          ok &= field_ok("entries_used", want.used, entries_used);
          ok &= field_ok("last_of_run", want.last, last_of_run);
          if (!ok) fail_count++;
          results_checked++;
        end
      end
      if (start && !busy) tally_request(opcode, term_code);
    end
    pending = expected_results.size();
  end

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import stfq_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int CODE_BITS   = DEF_CODE_BITS;
  localparam int COUNT_BITS  = DEF_COUNT_BITS;
  localparam int USED_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 180;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  opcode;
  logic [CODE_BITS-1:0]  term_code;
  logic                  result_strobe;
  logic [1:0]            result_kind;
  logic [CODE_BITS-1:0]  entry_code;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  was_inserted;
  logic                  table_full_drop;
  logic [USED_BITS-1:0]  entries_used;
  logic                  last_of_run;

  int fail_count;
  int pending;
  int results_checked;
  int drops_seen;
  int saturated_seen;
  int sent;
  bit burst;

  sorted_term_frequency_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_BITS  (CODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .term_code      (term_code),
    .result_strobe  (result_strobe),
    .result_kind    (result_kind),
    .entry_code     (entry_code),
    .entry_count    (entry_count),
    .was_inserted   (was_inserted),
    .table_full_drop(table_full_drop),
    .entries_used   (entries_used),
    .last_of_run    (last_of_run)
  );

  term_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_BITS  (CODE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .USED_BITS  (USED_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .term_code      (term_code),
    .result_strobe  (result_strobe),
    .result_kind    (result_kind),
    .entry_code     (entry_code),
    .entry_count    (entry_count),
    .was_inserted   (was_inserted),
    .table_full_drop(table_full_drop),
    .entries_used   (entries_used),
    .last_of_run    (last_of_run),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .drops_seen     (drops_seen),
    .saturated_seen (saturated_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("sorted_term_frequency_table: mismatch");
    $finish;
  end

  function automatic int unsigned pick_gap();
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // hold start high across back-to-back requests; drop it only for a gap
  task automatic send_request(input logic op, input logic [CODE_BITS-1:0] code,
                              input int unsigned gap);
    @(negedge clk);
    start     <= 1'b1;
    opcode    <= op;
    term_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (gap != 0) begin
      @(negedge clk);
      start     <= 1'b0;
      opcode    <= 1'($urandom);
      term_code <= CODE_BITS'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    logic [CODE_BITS-1:0] pool [16];
    int pool_size;
    int doc_len;
    int rand_goal;
    logic [CODE_BITS-1:0] code;

    rst       = 1'b1;
    start     = 1'b0;
    opcode    = OP_ADD;
    term_code = '0;
    sent      = 0;
    burst     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, hits, middle insert, single-entry and empty dumps
    send_request(OP_END, 16'h0000, 0);
    send_request(OP_END, 16'hFFFF, 2);
    send_request(OP_ADD, 16'h0000, 0);
    send_request(OP_ADD, 16'hFFFF, 1);
    send_request(OP_ADD, 16'h8000, 0);
    send_request(OP_ADD, 16'h0000, 0);
    send_request(OP_ADD, 16'hFFFF, 3);
    send_request(OP_ADD, 16'h0001, 0);
    send_request(OP_ADD, 16'hFFFE, 0);
    send_request(OP_END, 16'h1234, 0);
    send_request(OP_ADD, 16'h0005, 0);
    send_request(OP_END, 16'h0000, 0);
    send_request(OP_END, 16'h0000, 4);

    // fill in descending order so every insert after the first shifts, then overflow while full
    for (int k = TABLE_DEPTH - 1; k >= 0; k--)
      send_request(OP_ADD, CODE_BITS'(k * 1024 + 3), (k % 7 == 0) ? 2 : 0);
    send_request(OP_ADD, 16'h0000, 0);
    send_request(OP_ADD, 16'hFFFF, 1);
    send_request(OP_ADD, CODE_BITS'(5 * 1024 + 3), 0);
    send_request(OP_ADD, 16'h2000, 0);
    send_request(OP_END, 16'h0000, 5);

    // repeat one code back to back to build up its count
    send_request(OP_ADD, 16'h00F0, 0);
    repeat (3) send_request(OP_ADD, 16'h1234, 0);
    send_request(OP_ADD, 16'h00F0, 0);
    send_request(OP_END, 16'h0000, 3);

    rand_goal = sent + RANDOM_ITEMS;
    while (sent < rand_goal) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send_request(1'($urandom), CODE_BITS'($urandom), pick_gap());
      end else begin
        doc_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                                 : $urandom_range(0, 16);
        pool_size = $urandom_range(1, 10);
        for (int p = 0; p < pool_size; p++) begin
          if ($urandom_range(0, 7) == 0) pool[p] = $urandom_range(0, 1) ? '1 : '0;
          else pool[p] = CODE_BITS'($urandom);
        end
        repeat (doc_len) begin
          if (doc_len <= 16 && $urandom_range(0, 2) != 0)
            code = pool[$urandom_range(0, pool_size - 1)];
          else
            code = CODE_BITS'($urandom);
          send_request(OP_ADD, code, pick_gap());
        end
        send_request(OP_END, CODE_BITS'($urandom), pick_gap());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d requests; %0d results checked against the predicted table.",
             sent, results_checked);
    $display("Full-table drops: %0d, adds held at the count ceiling: %0d.",
             drops_seen, saturated_seen);
    if (fail_count == 0)
      $display("sorted_term_frequency_table: match");
    else
      $display("sorted_term_frequency_table: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
